[src/bas_pkg.sv]
// Shared types, constants and the segment encoder for the button accumulator.
// No dependencies; compile first.
`default_nettype none

package bas_pkg;

    localparam int DIGITS          = 6;
    localparam int COUNT_W         = 20;
    localparam int SWITCH_FIELD_W  = 10;
    localparam int BUTTON_W        = 4;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 20'd999999;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 20'hFFFFF;

    // floor(v / 10) == (v * DIV10_RECIP) >> DIV10_SHIFT for every 20-bit v
    localparam logic [COUNT_W-1:0] DIV10_RECIP = 20'd838861;
    localparam int                 DIV10_SHIFT = 23;

    // Button bit positions
    localparam int KEY_ADD   = 0;
    localparam int KEY_CLEAR = 1;
    localparam int KEY_STOP  = 3;

    typedef logic [7:0] seg_t;

    typedef struct packed {
        logic [BUTTON_W-1:0]       buttons;
        logic [SWITCH_FIELD_W-1:0] switch_value;
    } sample_t;

    typedef struct packed {
        logic [30:0] seg_low_word;
        logic [14:0] seg_high_word;
        logic        overflow_led;
        logic        updated;
        logic        stopped;
    } display_t;

    // Record carried down the digit pipeline
    typedef struct packed {
        logic [COUNT_W-1:0]   value;
        seg_t [DIGITS-1:0]    codes;
        logic                 blank;
        logic                 overflow;
        logic                 updated;
        logic                 stopped;
    } pipe_t;

    function automatic seg_t seg_encode(input logic [3:0] digit);
        seg_t code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[src/bas_sample_if.sv]
// Valid/ready channel carrying one button and switch sample per item.
// Depends on bas_pkg.
`default_nettype none

interface bas_sample_if;
    logic             valid;
    logic             ready;
    bas_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/bas_display_if.sv]
// Valid/ready channel carrying one display result per item.
// Depends on bas_pkg.
`default_nettype none

interface bas_display_if;
    logic              valid;
    logic              ready;
    bas_pkg::display_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/bas_ctrl.sv]
// Edge detection, counter update and stop state; registers the first
// pipeline record. Depends on bas_pkg.
`default_nettype none

module bas_ctrl #(
    parameter int SWITCH_WIDTH = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    input  wire bas_pkg::sample_t sample,
    output logic                  sample_ready,
    output logic                  front_valid,
    output bas_pkg::pipe_t        front,
    input  wire logic             front_ready
);
    import bas_pkg::*;

    localparam int USE_W = (SWITCH_WIDTH < SWITCH_FIELD_W) ? SWITCH_WIDTH : SWITCH_FIELD_W;
    localparam logic [SWITCH_FIELD_W-1:0] SW_MASK = SWITCH_FIELD_W'((1 << USE_W) - 1);

    logic [COUNT_W-1:0]  count_reg,  count_next;
    logic [BUTTON_W-1:0] prev_reg,   prev_next;
    logic                halted_reg, halted_next;
    logic                front_valid_reg;
    pipe_t               front_reg,  front_next;
    logic [BUTTON_W-1:0] edges;
    logic [COUNT_W:0]    sw_sum;
    logic                accept;

    assign sample_ready = !front_valid_reg || front_ready;
    assign accept       = sample_valid && sample_ready;
    assign front_valid  = front_valid_reg;
    assign front        = front_reg;

    always_comb
    begin
        edges       = sample.buttons & ~prev_reg;
        sw_sum      = {1'b0, count_reg} + (COUNT_W+1)'(sample.switch_value & SW_MASK);
        count_next  = count_reg;
        prev_next   = prev_reg;
        halted_next = halted_reg;
        if (!halted_reg)
        begin
            prev_next = sample.buttons;
            priority if (edges[KEY_ADD])
            begin
                if (count_reg < COUNT_LIMIT)
                begin
                    count_next = sw_sum[COUNT_W] ? COUNT_MAX : sw_sum[COUNT_W-1:0];
                end
            end
            else if (edges[KEY_CLEAR])
            begin
                count_next = '0;
            end
            else if (edges[KEY_STOP])
            begin
                halted_next = 1'b1;
            end
            else
            begin
                // no action edge: hold the counter
                count_next = count_reg;
            end
        end

        front_next.codes    = '0;
        front_next.blank    = halted_next;
        front_next.stopped  = halted_next;
        front_next.updated  = !halted_reg && (|edges);
        front_next.overflow = !halted_next && (count_next > COUNT_LIMIT);
        front_next.value    = (count_next > COUNT_LIMIT) ? COUNT_LIMIT : count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            prev_reg        <= '0;
            halted_reg      <= 1'b0;
            front_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg  <= count_next;
                prev_reg   <= prev_next;
                halted_reg <= halted_next;
            end
            if (sample_ready)
            begin
                front_valid_reg <= sample_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg <= front_next;
        end
    end

`ifndef SYNTH
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("stop state left");

    a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> $stable(count_reg) && $stable(prev_reg))
        else $error("state changed after stop");
`endif

endmodule

`default_nettype wire

[src/bas_digit.sv]
// One digit stage: divide by ten with a reciprocal multiply, encode the
// remainder and shift it into the code list. Depends on bas_pkg.
`default_nettype none

module bas_digit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    input  wire bas_pkg::pipe_t up_rec,
    output logic                up_ready,
    output logic                dn_valid,
    output bas_pkg::pipe_t      dn_rec,
    input  wire logic           dn_ready
);
    import bas_pkg::*;

    logic [2*COUNT_W-1:0] prod;
    logic [COUNT_W-1:0]   quot;
    logic [COUNT_W-1:0]   rem;
    pipe_t                rec_reg, rec_next;
    logic                 valid_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_rec   = rec_reg;

    always_comb
    begin
        prod           = (2*COUNT_W)'(up_rec.value) * (2*COUNT_W)'(DIV10_RECIP);
        quot           = COUNT_W'(prod >> DIV10_SHIFT);
        rem            = up_rec.value - ((quot << 3) + (quot << 1));
        rec_next       = up_rec;
        rec_next.value = quot;
        // newest digit enters at the top; after all stages the units sit lowest
        rec_next.codes = {seg_encode(rem[3:0]), up_rec.codes[DIGITS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rec_reg <= rec_next;
        end
    end

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && (rec_reg == $past(rec_reg)))
        else $error("digit stage lost a stalled item");
`endif

endmodule

`default_nettype wire

[src/button_accumulator_seven_segment.sv]
// Button accumulator with six-digit seven-segment display output.
// Throughput: one sample per cycle; ready drops only when the pipeline is full.
// Pipeline: the control register stage plus six divide-by-ten digit stages.
// Reset (async, active low): counter, previous buttons and stop flag cleared.
`default_nettype none

module button_accumulator_seven_segment #(
    parameter int SWITCH_WIDTH = 10
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bas_sample_if.sink    sample,
    bas_display_if.source display
);
    import bas_pkg::*;

    // stage 0 is the control register; stages 1..DIGITS are digit stages
    logic               stage_valid [DIGITS+1];
    logic               stage_ready [DIGITS+1];
    pipe_t              stage_rec   [DIGITS+1];
    pipe_t              last;

    // Detect edges, update the counter and register the record to convert
    bas_ctrl #(
        .SWITCH_WIDTH (SWITCH_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample       (sample.data),
        .sample_ready (sample.ready),
        .front_valid  (stage_valid[0]),
        .front        (stage_rec[0]),
        .front_ready  (stage_ready[0])
    );

    // Peel one decimal digit per stage, units first
    for (genvar g = 0; g < DIGITS; g++)
    begin : g_digit
        bas_digit u_digit (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[g]),
            .up_rec   (stage_rec[g]),
            .up_ready (stage_ready[g]),
            .dn_valid (stage_valid[g+1]),
            .dn_rec   (stage_rec[g+1]),
            .dn_ready (stage_ready[g+1])
        );
    end

    // Drive the result from the last stage register; blank when stopped
    assign last                       = stage_rec[DIGITS];
    assign stage_ready[DIGITS]        = display.ready;
    assign display.valid              = stage_valid[DIGITS];

    always_comb
    begin
        if (last.blank)
        begin
            display.data.seg_low_word  = '0;
            display.data.seg_high_word = '0;
        end
        else
        begin
            display.data.seg_low_word  = {last.codes[3][6:0], last.codes[2],
                                          last.codes[1], last.codes[0]};
            display.data.seg_high_word = {last.codes[5][6:0], last.codes[4]};
        end
        display.data.overflow_led = last.overflow;
        display.data.updated      = last.updated;
        display.data.stopped      = last.stopped;
    end

`ifndef SYNTH
    a_stop_blank: assert property (@(posedge clk) disable iff (!rst_n)
        display.valid && display.data.stopped |->
            display.data.seg_low_word == '0 && display.data.seg_high_word == '0
            && !display.data.overflow_led)
        else $error("stopped result not blanked");

    a_digits_lit: assert property (@(posedge clk) disable iff (!rst_n)
        display.valid && !display.data.stopped |->
            display.data.seg_low_word[6:0] != '0 && display.data.seg_high_word[14:8] != '0)
        else $error("digit code missing on live result");
`endif

endmodule

`default_nettype wire

[bench/tb_button_accumulator_seven_segment.sv]
`timescale 1ns / 100ps
// Self-checking testbench for button_accumulator_seven_segment.
// Depends on bas_pkg, bas_sample_if, bas_display_if and the block itself.
// Predicts each display word from the button samples and checks them in order.

module tb_button_accumulator_seven_segment;

    import bas_pkg::*;

    localparam int              SWITCH_WIDTH = 10;
    localparam logic [9:0]      SWITCH_MASK  = 10'((1 << SWITCH_WIDTH) - 1);
    localparam int              CYCLE_LIMIT  = 400000;
    localparam int              DRAIN_CYCLES = 20;
    localparam int              REPORT_MAX   = 10;
    localparam logic [7:0]      SEG_CODES [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bas_sample_if  sample_ch ();
    bas_display_if display_ch ();

    button_accumulator_seven_segment #(
        .SWITCH_WIDTH (SWITCH_WIDTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .display (display_ch)
    );

    // Predicted block state: counter, last button levels, stop flag
    logic [COUNT_W-1:0]  tally = '0;
    logic [BUTTON_W-1:0] last_buttons = '0;
    logic                halted = 1'b0;

    // Display words still owed by the block, oldest first
    display_t pending_displays [$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Idle and stall rates, in percent, for the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off: a test posts a length, the receiver takes it
    int hold_request = 0;
    int hold_left = 0;

    always #5 clk = ~clk;

    // Give up if the run hangs; a correct run ends far below this.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Advance the predicted state by one accepted sample and return the
    // display word that the block must produce for it.
    function automatic display_t predict_display(input sample_t item);
        display_t           word;
        logic [BUTTON_W-1:0] rising;
        logic [COUNT_W:0]   total;
        logic [COUNT_W-1:0] shown;
        logic [7:0]         codes [DIGITS];
        word = '0;
        // Once stopped, ignore everything and only flag the stop
        if (halted)
        begin
            word.stopped = 1'b1;
            return word;
        end
        rising = item.buttons & ~last_buttons;
        last_buttons = item.buttons;
        // One action per sample: add beats clear, clear beats stop
        if (rising[KEY_ADD])
        begin
            if (tally < COUNT_LIMIT)
            begin
                total = {1'b0, tally} + (COUNT_W+1)'(item.switch_value & SWITCH_MASK);
                tally = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_W-1:0];
            end
        end
        else if (rising[KEY_CLEAR])
        begin
            tally = '0;
        end
        else if (rising[KEY_STOP])
        begin
            halted = 1'b1;
            word.updated = 1'b1;
            word.stopped = 1'b1;
            return word;
        end
        // Saturate the shown value, then encode six decimal digits
        shown = (tally > COUNT_LIMIT) ? COUNT_LIMIT : tally;
        for (int i = 0; i < DIGITS; i++)
        begin
            codes[i] = SEG_CODES[shown % 10];
            shown = COUNT_W'(shown / 10);
        end
        word.seg_low_word  = 31'({codes[3], codes[2], codes[1], codes[0]});
        word.seg_high_word = 15'({codes[5], codes[4]});
        word.overflow_led  = (tally > COUNT_LIMIT);
        word.updated       = (rising != '0);
        return word;
    endfunction

    // Drop a key 3 press that would stop the block on its own, so that
    // random traffic keeps the block running until the stop test.
    function automatic logic [BUTTON_W-1:0] keep_running(input logic [BUTTON_W-1:0] keys);
        logic [BUTTON_W-1:0] rising;
        rising = keys & ~last_buttons;
        if (!halted && rising[KEY_STOP] && !rising[KEY_ADD] && !rising[KEY_CLEAR])
            keys[KEY_STOP] = 1'b0;
        return keys;
    endfunction

    // ------------------------------------------------------------------
    // Sample channel: every call starts and ends at a falling edge
    // ------------------------------------------------------------------

    task automatic send_sample(input logic [BUTTON_W-1:0] keys, input logic [9:0] sw);
        sample_t item;
        item.buttons = keys;
        item.switch_value = sw;
        // Insert random idle cycles ahead of the item
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= item;
        // Hold the item until the block takes it
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_displays.push_back(predict_display(item));
        @(negedge clk);
    endtask

    task automatic send_running(input logic [BUTTON_W-1:0] keys, input logic [9:0] sw);
        send_sample(keep_running(keys), sw);
    endtask

    // ------------------------------------------------------------------
    // Display channel: drive ready at the falling edge, check at the rising
    // ------------------------------------------------------------------

    initial
    begin
        display_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                // Long hold-off: let the pipeline fill and stall the input
                hold_left--;
                display_ch.ready <= 1'b0;
            end
            else
            begin
                display_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < REPORT_MAX)
                $display("mismatch in %s at cycle %0d: expected %h, got %h",
                         field, cycle_count, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        display_t want;
        display_t got;
        if (rst_n && display_ch.valid && display_ch.ready)
        begin
            got = display_ch.data;
            if (pending_displays.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected display item at cycle %0d: %h", cycle_count, got);
                mismatches++;
            end
            else
            begin
                want = pending_displays.pop_front();
                compare_field("seg_low_word", 32'(want.seg_low_word), 32'(got.seg_low_word));
                compare_field("seg_high_word", 32'(want.seg_high_word),
                              32'(got.seg_high_word));
                compare_field("overflow_led", 32'(want.overflow_led), 32'(got.overflow_led));
                compare_field("updated", 32'(want.updated), 32'(got.updated));
                compare_field("stopped", 32'(want.stopped), 32'(got.stopped));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked samples: display right after reset, held and released keys,
    // key 2 alone, simultaneous presses and the priority between them.
    task automatic test_directed();
        send_running(4'b0000, 10'h000);   // reset display, all zeros
        send_running(4'b0001, 10'h3FF);   // add the largest switch value
        send_running(4'b0001, 10'h005);   // key held: no edge, no add
        send_running(4'b0000, 10'h3FF);   // release
        send_running(4'b0100, 10'h123);   // key 2 alone: flag update only
        send_running(4'b0101, 10'h000);   // add zero while key 2 is held
        send_running(4'b0000, 10'h000);
        send_running(4'b0011, 10'h007);   // add and clear together: add wins
        send_running(4'b0000, 10'h000);
        send_running(4'b0010, 10'h3FF);   // clear
        send_running(4'b0000, 10'h000);
        send_running(4'b1001, 10'h001);   // add and stop together: add wins
        send_running(4'b1000, 10'h000);   // key 3 held, no new edge
        send_running(4'b1010, 10'h000);   // clear while key 3 held
        send_running(4'b0000, 10'h000);
        send_running(4'b0001, 10'h2AA);   // alternating switch bits
        send_running(4'b0000, 10'h155);
        send_running(4'b0001, 10'h155);
        send_running(4'b0000, 10'h2AA);
        send_running(4'b1110, 10'h000);   // clear beats a fresh edge on key 3
        send_running(4'b0000, 10'h000);
        send_running(4'b0001, 10'h3FF);   // add with key 3 released: no stop
        send_running(4'b0000, 10'h000);
    endtask

    // Mostly well-formed press and release pairs with random content,
    // plus some raw noise on all buttons.
    task automatic run_random_traffic(input int idle_pct, input int stall_pct,
                                      input int item_count);
        int sent;
        int pick;
        sent = 0;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < item_count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                send_running({1'($urandom_range(1)), 1'($urandom_range(1)), 2'b01},
                             10'($urandom_range(1023)));
                send_running({1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'b0}, 10'($urandom_range(1023)));
                sent += 2;
            end
            else if (pick < 68)
            begin
                send_running({1'($urandom_range(1)), 1'($urandom_range(1)), 2'b10},
                             10'($urandom_range(1023)));
                send_running(4'b0000, 10'($urandom_range(1023)));
                sent += 2;
            end
            else if (pick < 82)
            begin
                send_running({1'($urandom_range(1)), 3'b100}, 10'($urandom_range(1023)));
                send_running(4'b0000, 10'($urandom_range(1023)));
                sent += 2;
            end
            else
            begin
                send_running(4'($urandom_range(15)), 10'($urandom_range(1023)));
                sent += 1;
            end
        end
    endtask

    // Hold the receiver off for a long stretch while samples keep coming,
    // so the block fills and drops its input ready.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 80;
        for (int i = 0; i < 40; i++)
            send_running(4'($urandom_range(15)), 10'($urandom_range(1023)));
    endtask

    // Stop with a lone edge on key 3, then confirm every later sample is ignored.
    task automatic test_stop();
        send_idle_pct = 8;
        recv_stall_pct = 8;
        send_running(4'b0000, 10'h000);
        send_sample(4'b1000, 10'h3FF);
        for (int i = 0; i < 24; i++)
            send_sample(4'($urandom_range(15)), 10'($urandom_range(1023)));
        send_sample(4'b0000, 10'h000);
        send_sample(4'b0001, 10'h3FF);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        run_random_traffic(0, 0, 110);
        run_random_traffic(75, 0, 110);
        run_random_traffic(0, 75, 110);
        test_backpressure();
        run_random_traffic(8, 8, 110);
        run_random_traffic(0, 0, 30);
        test_stop();

        // Drop valid, let the receiver run freely, drain the pipeline
        sample_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
